@@ design/gdt_pkg.sv @@
`timescale 1ns / 1ps
package gdt_pkg;

  localparam int VALUE_WIDTH = 32;
  // Enough decimal digits for any magnitude up to 2**VALUE_WIDTH - 1
  localparam int NUM_DIGITS  = ((VALUE_WIDTH * 1233) >> 12) + 1;
  localparam int DIG_IDX_W   = $clog2(NUM_DIGITS);
  localparam int BIT_CNT_W   = $clog2(VALUE_WIDTH);
  localparam int SIZE_W      = 5;
  localparam int CHAR_W      = 7;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [CHAR_W-1:0] CHAR_NUL   = 7'd0;
  localparam logic [CHAR_W-1:0] CHAR_SEP   = 7'd39;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'd45;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;

  typedef struct packed {
    logic                   neg;
    logic [VALUE_WIDTH-1:0] mag;
  } gdt_item_t;

endpackage

@@ design/gdt_front.sv @@
`timescale 1ns / 1ps
module gdt_front import gdt_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [VALUE_WIDTH-1:0] value_i,
  output logic                   push_valid_o,
  input  logic                   push_ready_i,
  output gdt_item_t              push_item_o
);

  logic      full_q, full_d;
  gdt_item_t item_q, item_d;
  logic      accept;

  assign in_stall_o = full_q && !push_ready_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    full_d = full_q;
    item_d = item_q;
    if (full_q && push_ready_i) begin
      full_d = 1'b0;
    end
    if (accept) begin
      full_d     = 1'b1;
      // Split sign and take magnitude as unsigned
      item_d.neg = value_i[VALUE_WIDTH-1];
      item_d.mag = value_i[VALUE_WIDTH-1] ? (~value_i + 1'b1) : value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else begin
      full_q <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign push_valid_o = full_q;
  assign push_item_o  = item_q;

endmodule

@@ design/gdt_queue.sv @@
`timescale 1ns / 1ps
module gdt_queue import gdt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_valid_i,
  output logic      push_ready_o,
  input  gdt_item_t push_item_i,
  output logic      pop_valid_o,
  input  logic      pop_ready_i,
  output gdt_item_t pop_item_o
);

  gdt_item_t          mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]    count_q, count_d;
  logic               push, pop;

  assign push_ready_o = (count_q != (QPTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

@@ design/gdt_back.sv @@
`timescale 1ns / 1ps
module gdt_back import gdt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [SIZE_W-1:0] buffer_size_i,
  input  logic              pop_valid_i,
  output logic              pop_ready_o,
  input  gdt_item_t         pop_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [CHAR_W-1:0] char_code_o,
  output logic              last_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]                  state_q, state_d;
  logic [VALUE_WIDTH-1:0]      mag_q, mag_d;
  logic [NUM_DIGITS-1:0][3:0]  bcd_q, bcd_d;
  logic [4*NUM_DIGITS-1:0]     bcd_adj;
  logic [BIT_CNT_W-1:0]        bit_cnt_q, bit_cnt_d;
  logic [DIG_IDX_W-1:0]        idx_q, idx_d;
  logic [1:0]                  grp_q, grp_d, grp_dec;
  logic [SIZE_W-1:0]           cnt_q, cnt_d, keep;
  logic                        neg_q, neg_d, sep_q, sep_d, done_q, done_d;
  logic                        out_valid_q, out_valid_d, last_q, last_d;
  logic [CHAR_W-1:0]           char_q, char_d;
  logic                        can_push;

  assign can_push    = !out_valid_q || !out_stall_i;
  assign pop_ready_o = (state_q == ST_IDLE);
  assign keep        = buffer_size_i - 1'b1;
  assign grp_dec     = (grp_q == 2'd0) ? 2'd2 : grp_q - 1'b1;

  // Add-3 correction on every digit before the shift
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
    end
  end

  always_comb begin
    state_d     = state_q;
    mag_d       = mag_q;
    bcd_d       = bcd_q;
    bit_cnt_d   = bit_cnt_q;
    idx_d       = idx_q;
    grp_d       = grp_q;
    cnt_d       = cnt_q;
    neg_d       = neg_q;
    sep_d       = sep_q;
    done_d      = done_q;
    out_valid_d = out_valid_q;
    char_d      = char_q;
    last_d      = last_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        // Drop the item outright when there is no room at all
        if (pop_valid_i && (buffer_size_i != '0)) begin
          state_d   = ST_CONV;
          neg_d     = pop_item_i.neg;
          mag_d     = pop_item_i.mag;
          bcd_d     = '0;
          bit_cnt_d = BIT_CNT_W'(VALUE_WIDTH - 1);
        end
      end
      ST_CONV: begin
        bcd_d = {bcd_adj[4*NUM_DIGITS-2:0], mag_q[VALUE_WIDTH-1]};
        mag_d = {mag_q[VALUE_WIDTH-2:0], 1'b0};
        if (bit_cnt_q == '0) begin
          state_d = ST_SCAN;
          idx_d   = DIG_IDX_W'(NUM_DIGITS - 1);
          grp_d   = 2'(NUM_DIGITS % 3);
        end else begin
          bit_cnt_d = bit_cnt_q - 1'b1;
        end
      end
      ST_SCAN: begin
        // Skip leading zeros, keep one digit at least
        if ((bcd_q[idx_q] == 4'd0) && (idx_q != '0)) begin
          idx_d = idx_q - 1'b1;
          grp_d = grp_dec;
        end else begin
          state_d = ST_EMIT;
          sep_d   = 1'b0;
          done_d  = 1'b0;
          cnt_d   = '0;
        end
      end
      ST_EMIT: begin
        if (can_push) begin
          out_valid_d = 1'b1;
          priority if (done_q || (cnt_q == keep)) begin
            char_d  = CHAR_NUL;
            last_d  = 1'b1;
            state_d = ST_IDLE;
          end else if (neg_q) begin
            char_d = CHAR_MINUS;
            last_d = 1'b0;
            neg_d  = 1'b0;
            cnt_d  = cnt_q + 1'b1;
          end else if (sep_q) begin
            char_d = CHAR_SEP;
            last_d = 1'b0;
            sep_d  = 1'b0;
            cnt_d  = cnt_q + 1'b1;
          end else begin
            char_d = CHAR_ZERO | {3'b000, bcd_q[idx_q]};
            last_d = 1'b0;
            cnt_d  = cnt_q + 1'b1;
            if (idx_q == '0) begin
              done_d = 1'b1;
            end else begin
              idx_d = idx_q - 1'b1;
              grp_d = grp_dec;
              sep_d = (grp_dec == 2'd0);
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q     <= mag_d;
    bcd_q     <= bcd_d;
    bit_cnt_q <= bit_cnt_d;
    idx_q     <= idx_d;
    grp_q     <= grp_d;
    cnt_q     <= cnt_d;
    neg_q     <= neg_d;
    sep_q     <= sep_d;
    done_q    <= done_d;
    char_q    <= char_d;
    last_q    <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign char_code_o = char_q;
  assign last_o      = last_q;

endmodule

@@ design/grouped_decimal_text.sv @@
`timescale 1ns / 1ps
// Grouped decimal text: turns one signed 32-bit integer into ASCII characters,
// e.g. -1234567 becomes "-1'234'567" followed by a NUL that carries last_o.
// Input channel: in_valid_i / in_stall_o with value_i; a transfer happens on
// a rising edge where valid is high and stall is low. Output channel:
// out_valid_o / out_stall_i with char_code_o and last_o, one character per
// transfer. cfg_we_i / cfg_data_i write buffer_size (room including the NUL);
// write it only while the block is idle. Text is cut to buffer_size - 1
// characters; a buffer_size of zero drops the item with no output.
// Path: the front register and the queue, shift-and-add-3 conversion (one
// magnitude bit per cycle), a leading-zero scan, then one character per cycle
// while the receiver does not stall (1 to 15 including the NUL). The back end
// takes a new item only once it is through with the last one, so the
// converter and the emitter set the throughput.
// While the receiver stalls, the output register holds its character and
// the emitter waits; the queue keeps taking items until it fills.
// Reset (rst_ni low, asynchronous) empties the queue and output register and
// sets buffer_size to 16.
module grouped_decimal_text import gdt_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [SIZE_W-1:0]      cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [VALUE_WIDTH-1:0] value_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [CHAR_W-1:0]      char_code_o,
  output logic                   last_o
);

  logic [SIZE_W-1:0] buffer_size_q;
  logic              push_valid, push_ready, pop_valid, pop_ready;
  gdt_item_t         push_item, pop_item;

  // Hold the room setting; the user must change it only between items, the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buffer_size_q <= SIZE_W'(16);
    end else if (cfg_we_i) begin
      buffer_size_q <= cfg_data_i;
    end
  end

  // Front: take the transfer, split sign and magnitude
  gdt_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .value_i      (value_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  // Decouple front from the slow converter
  gdt_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  // Back: convert to decimal, insert separators, emit characters
  gdt_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .buffer_size_i (buffer_size_q),
    .pop_valid_i   (pop_valid),
    .pop_ready_o   (pop_ready),
    .pop_item_i    (pop_item),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .char_code_o   (char_code_o),
    .last_o        (last_o)
  );

endmodule

@@ sim/grouped_decimal_text_test.sv @@
`timescale 1ns / 1ps

// One character transfer as the output channel presents it
typedef struct packed {
  logic [gdt_pkg::CHAR_W-1:0] code;
  logic                       last;
} text_char_t;

class grouped_text_scoreboard;
  localparam int DIGITS_PER_GROUP = 3;
  localparam int REPORT_LIMIT     = 10;

  text_char_t                   awaited[$];
  logic [gdt_pkg::SIZE_W-1:0]   room;
  int                           mismatches;

  function new();
    room       = 5'd16;
    mismatches = 0;
  endfunction

  function void flag(string what);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("%s", what);
  endfunction

  // Format an accepted value and queue the characters it must produce
  function void note_value(logic [gdt_pkg::VALUE_WIDTH-1:0] value);
    logic [gdt_pkg::VALUE_WIDTH-1:0] mag;
    logic [gdt_pkg::CHAR_W-1:0]      digits[$];
    logic [gdt_pkg::CHAR_W-1:0]      text[$];
    int                              keep;
    if (room == 0) return;
    mag = value[gdt_pkg::VALUE_WIDTH-1] ? -value : value;
    do begin
      digits.push_front(gdt_pkg::CHAR_ZERO + gdt_pkg::CHAR_W'(mag % 10));
      mag = mag / 10;
    end while (mag != 0);
    if (value[gdt_pkg::VALUE_WIDTH-1]) text.push_back(gdt_pkg::CHAR_MINUS);
    foreach (digits[i]) begin
      if (i > 0 && (digits.size() - i) % DIGITS_PER_GROUP == 0) begin
        text.push_back(gdt_pkg::CHAR_SEP);
      end
      text.push_back(digits[i]);
    end
    keep = int'(room) - 1;
    if (keep > int'(text.size())) keep = int'(text.size());
    for (int i = 0; i < keep; i++) awaited.push_back('{code: text[i], last: 1'b0});
    awaited.push_back('{code: gdt_pkg::CHAR_NUL, last: 1'b1});
  endfunction

  function void check_glyph(logic [gdt_pkg::CHAR_W-1:0] code, logic last);
    text_char_t want;
    if (awaited.size() == 0) begin
      flag($sformatf("unexpected character: char_code %0d last %0d", code, last));
      return;
    end
    want = awaited.pop_front();
    if (want.code !== code) begin
      flag($sformatf("char_code mismatch: expected %0d, got %0d", want.code, code));
    end
    if (want.last !== last) begin
      flag($sformatf("last mismatch: expected %0d, got %0d", want.last, last));
    end
  endfunction
endclass

module grouped_decimal_text_test;
  import gdt_pkg::*;

  // The block may still be chewing on items with zero room after the last
  // expected character, so hold this long before touching the register.
  localparam int QUIET_CYCLES = 400;
  localparam int TAIL_CYCLES  = 100;
  localparam int HOLD_CYCLES  = 500;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int PHASES       = 17;
  localparam int PHASE_ITEMS  = 28;
  localparam int ZERO_ITEMS   = 6;
  localparam int PRESSURE_PHASE = 4;

  typedef enum int {
    FLOW_FREE,
    FLOW_SENDER_IDLE,
    FLOW_RECEIVER_STALL,
    FLOW_BOTH
  } flow_mode_e;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [SIZE_W-1:0]      cfg_data_i;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic [VALUE_WIDTH-1:0] value_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  logic [CHAR_W-1:0]      char_code_o;
  logic                   last_o;

  grouped_text_scoreboard board;
  int unsigned            send_idle_pct = 0;
  int unsigned            recv_stall_pct = 0;
  bit                     hold_request = 1'b0;
  int                     hold_left = 0;
  int                     cycle_count = 0;
  logic [SIZE_W-1:0]      room_setting;

  // Directed values: extremes, each group boundary, the most negative value
  int reset_room_values[11] = '{0, 1, -1, 12, 123, 1234, -12345, 999999, 1000000,
                                2147483647, 32'h8000_0000};
  int wide_room_values[3]   = '{32'h8000_0000, -1000, 100};
  int cut_room_values[2]    = '{-1234567, 123456};
  int zero_room_values[2]   = '{7, -7};

  grouped_decimal_text dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .char_code_o (char_code_o),
    .last_o      (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Guard against a hung handshake
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver: random stall, or a long hold-off when one is requested so the
  // block backs up all the way to its input.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  // Check every character transfer against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.check_glyph(char_code_o, last_o);
  end

  // Offer one value; hold it steady until the transfer happens
  task automatic send_value(input logic [VALUE_WIDTH-1:0] v);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    value_i    <= v;
    do @(posedge clk_i); while (in_stall_o);
    board.note_value(v);
  endtask

  // Drain, let the converter settle, then write buffer_size
  task automatic set_room(input logic [SIZE_W-1:0] sz);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (board.awaited.size() != 0) @(posedge clk_i);
    repeat (QUIET_CYCLES) @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= sz;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    board.room = sz;
  endtask

  task automatic set_flow(input flow_mode_e mode);
    case (mode)
      FLOW_FREE: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      FLOW_SENDER_IDLE: begin
        send_idle_pct  = 81;
        recv_stall_pct = 0;
      end
      FLOW_RECEIVER_STALL: begin
        send_idle_pct  = 0;
        recv_stall_pct = 81;
      end
      default: begin
        send_idle_pct  = 21;
        recv_stall_pct = 21;
      end
    endcase
  endtask

  // Mix full-width noise, magnitudes of every digit count, and corner values
  function automatic logic [VALUE_WIDTH-1:0] random_value();
    logic [VALUE_WIDTH-1:0] mag;
    int unsigned            span;
    int                     ndigits;
    span = 1;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom();
      4, 5, 6, 7: begin
        ndigits = $urandom_range(1, 9);
        repeat (ndigits) span = span * 10;
        mag = $urandom_range(0, span - 1);
        return $urandom_range(0, 1) ? -mag : mag;
      end
      default: begin
        case ($urandom_range(0, 7))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'h8000_0001;
          3: return '0;
          4: return '1;
          5: return 32'd1000;
          6: return -32'd999;
          default: return -32'd1000000;
        endcase
      end
    endcase
  endfunction

  initial begin
    board      = new();
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    value_i    = '0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, starting on the reset room of sixteen
    foreach (reset_room_values[i]) send_value(reset_room_values[i]);
    set_room(5'd31);
    foreach (wide_room_values[i]) send_value(wide_room_values[i]);
    set_room(5'd5);
    foreach (cut_room_values[i]) send_value(cut_room_values[i]);
    set_room(5'd1);
    send_value(42);
    set_room(5'd0);
    foreach (zero_room_values[i]) send_value(zero_room_values[i]);

    // Random phases, each with its own room and flow pattern
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       room_setting = 5'd31;
        1:       room_setting = 5'd0;
        2:       room_setting = 5'd1;
        3:       room_setting = 5'd2;
        default: room_setting = SIZE_W'($urandom_range(1, 31));
      endcase
      set_room(room_setting);
      set_flow(flow_mode_e'(p % 4));
      if (p == PRESSURE_PHASE) begin
        @(posedge clk_i);
        hold_request = 1'b1;
      end
      repeat (room_setting == 0 ? ZERO_ITEMS : PHASE_ITEMS) send_value(random_value());
    end

    // Drop valid, drain, then watch a little longer for stray characters
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (board.awaited.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (board.mismatches == 0 && board.awaited.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
